// ===== design/ipatv_pkg.sv =====
// Package for the IP address text validator: phase codes, state record, limits, char helpers.
package ipatv_pkg;

    typedef enum logic [2:0] {
        PH_EXPECT = 3'd0,
        PH_COLON  = 3'd1,
        PH_DOUBLE = 3'd2,
        PH_GROUP  = 3'd3,
        PH_DOT    = 3'd4,
        PH_OCTET  = 3'd5
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  run_length;
        logic [9:0]  run_value;
        logic        run_all_dec;
        logic        run_lead_zero;
        logic [3:0]  group_count;
        logic        compressed;
        logic [2:0]  octet_count;
        logic        failed;
        logic [1:0]  lead_pos;
    } state_t;

    localparam logic       FAMILY_V4      = 1'b0;
    localparam logic       FAMILY_V6      = 1'b1;
    localparam logic [9:0] OCTET_MAX      = 10'd255;
    localparam logic [2:0] OCTET_DIGITS   = 3'd3;
    localparam logic [2:0] GROUP_DIGITS   = 3'd4;
    localparam logic [2:0] RUN_SAT        = 3'd7;
    localparam logic [2:0] DOTS_MAX       = 3'd3;
    localparam logic [3:0] GROUPS_FULL    = 4'd8;
    localparam logic [3:0] GROUPS_COMP    = 4'd7;
    localparam logic [3:0] TAIL_GROUP_MAX = 4'd6;
    localparam logic [1:0] LEAD_SAT       = 2'd3;
    localparam logic [7:0] CH_COLON       = 8'h3A;
    localparam logic [7:0] CH_DOT         = 8'h2E;
    localparam logic [7:0] CH_ZERO        = 8'h30;

    localparam state_t STATE_CLEAR = '{
        phase:         PH_EXPECT,
        run_length:    3'd0,
        run_value:     10'd0,
        run_all_dec:   1'b1,
        run_lead_zero: 1'b0,
        group_count:   4'd0,
        compressed:    1'b0,
        octet_count:   3'd0,
        failed:        1'b0,
        lead_pos:      2'd0
    };

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

endpackage

// ===== design/ip_address_text_validator_top.sv =====
// Top level of the IP address text validator: per-character state update and verdict register.
//
// Input channel (in_valid/in_ready) moves one word per string character:
// character, last, and no_character (word carries no byte). A word with
// no_character and last ends the string; alone it is an empty string and
// fails. Output channel (out_valid/out_ready) moves one word, valid_res,
// for each accepted input word with last set; other words give nothing.
// cfg_we/cfg_wdata write address_family (0 IPv4 dotted quad, 1 IPv6);
// write it only between strings.
// Each character updates the running string state in the cycle it is
// accepted; one word per cycle while in_ready is high. The verdict appears
// on out_valid the cycle after the last word is accepted.
// When the receiver stalls, the verdict waits in the result register and
// in_ready drops only while that register is full and not being taken.
// Reset clears the string state and the valid flag of the result register
// (valid_res itself is not reset) and sets address_family to IPv6.
module ip_address_text_validator_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] character,
    input  logic       last,
    input  logic       no_character,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       valid_res
);
    import ipatv_pkg::*;

    logic   family_reg;
    state_t st_reg;
    state_t st_next;
    logic   out_valid_reg;
    logic   valid_res_reg;
    logic   verdict_next;
    logic   accept;

    logic       c_dec;
    logic       c_hex;
    logic [3:0] dig;
    logic [2:0] len_ext;
    logic       all_ext;
    logic [9:0] val_ext;
    logic [9:0] val_start;
    logic [3:0] groups;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign valid_res = valid_res_reg;

    assign c_dec     = is_dec(character);
    assign c_hex     = is_hex(character);
    assign dig       = character[3:0];
    assign val_start = c_dec ? {6'd0, dig} : 10'd0;
    assign len_ext   = (st_reg.run_length < RUN_SAT) ? st_reg.run_length + 3'd1
                                                    : st_reg.run_length;
    assign all_ext   = st_reg.run_all_dec && c_dec;
    assign val_ext   = (all_ext && (len_ext <= OCTET_DIGITS))
                     ? ({st_reg.run_value[6:0], 3'b000} + {st_reg.run_value[8:0], 1'b0}
                        + {6'd0, dig})
                     : st_reg.run_value;

    always_comb
    begin : next_state
        st_next = st_reg;
        if (!no_character)
        begin
            if (!st_reg.failed)
            begin
                if (family_reg == FAMILY_V4)
                begin
                    unique case (st_reg.phase)
                        PH_EXPECT, PH_DOT:
                        begin
                            if (c_dec)
                            begin
                                st_next.run_length    = 3'd1;
                                st_next.run_all_dec   = 1'b1;
                                st_next.run_lead_zero = (character == CH_ZERO);
                                st_next.run_value     = val_start;
                                st_next.phase         = PH_OCTET;
                            end
                            else
                            begin
                                st_next.failed = 1'b1;
                            end
                        end
                        PH_OCTET:
                        begin
                            if (c_dec)
                            begin
                                if (st_reg.run_lead_zero || (st_reg.run_length >= OCTET_DIGITS))
                                begin
                                    st_next.failed = 1'b1;
                                end
                                else
                                begin
                                    st_next.run_length  = len_ext;
                                    st_next.run_all_dec = all_ext;
                                    st_next.run_value   = val_ext;
                                    st_next.failed      = (val_ext > OCTET_MAX);
                                end
                            end
                            else if (character == CH_DOT)
                            begin
                                if (st_reg.octet_count >= DOTS_MAX)
                                begin
                                    st_next.failed = 1'b1;
                                end
                                else
                                begin
                                    st_next.octet_count = st_reg.octet_count + 3'd1;
                                    st_next.phase       = PH_DOT;
                                end
                            end
                            else
                            begin
                                st_next.failed = 1'b1;
                            end
                        end
                        default:
                        begin
                            st_next.failed = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    unique case (st_reg.phase)
                        PH_EXPECT:
                        begin
                            if ((character == CH_COLON) && (st_reg.lead_pos == 2'd0))
                            begin
                                st_next.phase = PH_COLON;
                            end
                            else if (c_hex)
                            begin
                                st_next.run_length    = 3'd1;
                                st_next.run_all_dec   = c_dec;
                                st_next.run_lead_zero = (character == CH_ZERO);
                                st_next.run_value     = val_start;
                                st_next.phase         = PH_GROUP;
                            end
                            else
                            begin
                                st_next.failed = 1'b1;
                            end
                        end
                        PH_COLON:
                        begin
                            if (character == CH_COLON)
                            begin
                                if (st_reg.compressed)
                                begin
                                    st_next.failed = 1'b1;
                                end
                                else
                                begin
                                    st_next.compressed = 1'b1;
                                    st_next.phase      = PH_DOUBLE;
                                end
                            end
                            else if ((st_reg.lead_pos != 2'd1) && c_hex)
                            begin
                                st_next.run_length    = 3'd1;
                                st_next.run_all_dec   = c_dec;
                                st_next.run_lead_zero = (character == CH_ZERO);
                                st_next.run_value     = val_start;
                                st_next.phase         = PH_GROUP;
                            end
                            else
                            begin
                                st_next.failed = 1'b1;
                            end
                        end
                        PH_DOUBLE:
                        begin
                            if (c_hex)
                            begin
                                st_next.run_length    = 3'd1;
                                st_next.run_all_dec   = c_dec;
                                st_next.run_lead_zero = (character == CH_ZERO);
                                st_next.run_value     = val_start;
                                st_next.phase         = PH_GROUP;
                            end
                            else
                            begin
                                st_next.failed = 1'b1;
                            end
                        end
                        PH_GROUP:
                        begin
                            if (c_hex)
                            begin
                                if (st_reg.run_length >= GROUP_DIGITS)
                                begin
                                    st_next.failed = 1'b1;
                                end
                                else
                                begin
                                    st_next.run_length  = len_ext;
                                    st_next.run_all_dec = all_ext;
                                    st_next.run_value   = val_ext;
                                end
                            end
                            else if (character == CH_COLON)
                            begin
                                st_next.group_count = st_reg.group_count + 4'd1;
                                if (st_reg.group_count >= GROUPS_FULL)
                                begin
                                    st_next.failed = 1'b1;
                                end
                                else
                                begin
                                    st_next.phase = PH_COLON;
                                end
                            end
                            else if (character == CH_DOT)
                            begin
                                if (!st_reg.run_all_dec || (st_reg.run_length > OCTET_DIGITS) ||
                                    ((st_reg.run_length > 3'd1) && st_reg.run_lead_zero) ||
                                    (st_reg.run_value > OCTET_MAX) ||
                                    (st_reg.group_count > TAIL_GROUP_MAX))
                                begin
                                    st_next.failed = 1'b1;
                                end
                                else
                                begin
                                    st_next.group_count = st_reg.group_count + 4'd2;
                                    st_next.octet_count = 3'd1;
                                    st_next.phase       = PH_DOT;
                                end
                            end
                            else
                            begin
                                st_next.failed = 1'b1;
                            end
                        end
                        PH_DOT:
                        begin
                            if (c_dec)
                            begin
                                st_next.run_length    = 3'd1;
                                st_next.run_all_dec   = 1'b1;
                                st_next.run_lead_zero = (character == CH_ZERO);
                                st_next.run_value     = val_start;
                                st_next.phase         = PH_OCTET;
                            end
                            else
                            begin
                                st_next.failed = 1'b1;
                            end
                        end
                        PH_OCTET:
                        begin
                            if (c_dec)
                            begin
                                if (st_reg.run_lead_zero || (st_reg.run_length >= OCTET_DIGITS))
                                begin
                                    st_next.failed = 1'b1;
                                end
                                else
                                begin
                                    st_next.run_length  = len_ext;
                                    st_next.run_all_dec = all_ext;
                                    st_next.run_value   = val_ext;
                                    st_next.failed      = (val_ext > OCTET_MAX);
                                end
                            end
                            else if (character == CH_DOT)
                            begin
                                if (st_reg.octet_count >= DOTS_MAX)
                                begin
                                    st_next.failed = 1'b1;
                                end
                                else
                                begin
                                    st_next.octet_count = st_reg.octet_count + 3'd1;
                                    st_next.phase       = PH_DOT;
                                end
                            end
                            else
                            begin
                                st_next.failed = 1'b1;
                            end
                        end
                        default:
                        begin
                            st_next.failed = 1'b1;
                        end
                    endcase
                end
            end
            if (st_reg.lead_pos < LEAD_SAT)
            begin
                st_next.lead_pos = st_reg.lead_pos + 2'd1;
            end
        end
    end

    always_comb
    begin : verdict
        groups       = st_next.group_count;
        verdict_next = 1'b0;
        if (!st_next.failed)
        begin
            if (family_reg == FAMILY_V4)
            begin
                verdict_next = (st_next.phase == PH_OCTET) && (st_next.octet_count == DOTS_MAX);
            end
            else
            begin
                if (st_next.phase == PH_GROUP)
                begin
                    groups = st_next.group_count + 4'd1;
                end
                if ((st_next.phase == PH_GROUP) || (st_next.phase == PH_DOUBLE) ||
                    ((st_next.phase == PH_OCTET) && (st_next.octet_count == DOTS_MAX)))
                begin
                    verdict_next = st_next.compressed ? (groups <= GROUPS_COMP)
                                                      : (groups == GROUPS_FULL);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            family_reg    <= FAMILY_V6;
            st_reg        <= STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                family_reg <= cfg_wdata;
            end
            if (accept)
            begin
                st_reg <= last ? STATE_CLEAR : st_next;
            end
            if (accept && last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last)
        begin
            valid_res_reg <= verdict_next;
        end
    end

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> out_valid)
        else $error("last word accepted without a result");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> (st_reg.phase == PH_EXPECT) && !st_reg.failed &&
                           (st_reg.lead_pos == 2'd0) && (st_reg.group_count == 4'd0))
        else $error("string state not cleared after last word");

    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.failed && !(accept && last) |=> st_reg.failed)
        else $error("failure flag dropped within a string");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty result register");

    a_group_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.group_count <= 4'd9)
        else $error("group count out of range");

endmodule
